// ===== rtl/sam_pkg.sv =====
// Shared constants and types for the sort-and-merge block.
// Command and status structs that join the controller and the datapath.
// No dependencies.
`default_nettype none

package sam_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int DATA_W     = 32;
    // count holds 0..LIST_DEPTH, index holds 0..LIST_DEPTH-1
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [IDX_W-1:0]         t_idx;

    // controller -> datapath, one strobe per micro-operation
    typedef struct packed {
        logic load;       // store the accepted input transaction
        logic sort_init;  // restart sort at list 0, p = 0, clear merge heads
        logic next_list;  // move sort to list 1, p = 0
        logic rd_p;       // read entry p, set q = p + 1
        logic ld_cur;     // latch entry p as running minimum, read entry q
        logic cmp;        // compare/swap entry q, read entry q + 1
        logic wr_p;       // write running minimum back to p, advance p
        logic rd_heads;   // read both merge heads
        logic emit;       // load output register with the smaller head
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sel;        // list under sort
        logic p_done;     // no pass left for this list
        logic q_last;     // current q is the last entry of the list
        logic out_free;   // output register can take a result this cycle
        logic emit_last;  // the pending emit is the final one of the run
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/sam_ram.sv =====
// List store: one write port, one read port with registered read data.
// Depends on sam_pkg for depth and data width.
`default_nettype none

module sam_ram (
    input  wire                 i_clk,
    input  wire                 i_wr_en,
    input  wire sam_pkg::t_idx  i_wr_addr,
    input  wire sam_pkg::t_data i_wr_data,
    input  wire                 i_rd_en,
    input  wire sam_pkg::t_idx  i_rd_addr,
    output sam_pkg::t_data      o_rd_data
);

    sam_pkg::t_data r_mem [sam_pkg::LIST_DEPTH];
    sam_pkg::t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/sam_datapath.sv =====
// Datapath: two list stores, fill counts, sort pointers, merge heads and
// the output register. Driven by sam_ctrl commands. Depends on sam_pkg, sam_ram.
`default_nettype none

module sam_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire sam_pkg::t_cmd  i_cmd,
    output sam_pkg::t_sts       o_sts,
    input  wire                 i_list_id,
    input  wire sam_pkg::t_data i_value,
    input  wire                 i_stall,
    output logic                o_valid,
    output sam_pkg::t_data      o_value_res,
    output logic                o_from_list,
    output logic                o_overflow,
    output logic                o_end_of_run
);

    localparam sam_pkg::t_cnt DEPTH_C = sam_pkg::CNT_W'(sam_pkg::LIST_DEPTH);
    localparam sam_pkg::t_cnt ONE_C   = sam_pkg::CNT_W'(1);

    sam_pkg::t_cnt  r_cnt0, r_cnt1, n_cnt0, n_cnt1;
    logic           r_drop, n_drop;
    sam_pkg::t_cnt  r_p, r_q, r_a, r_b, n_p, n_q, n_a, n_b;
    logic           r_sel, n_sel;
    sam_pkg::t_data r_cur, n_cur;
    logic           r_out_vld, n_out_vld;
    sam_pkg::t_data r_out_val, n_out_val;
    logic           r_out_src, n_out_src, r_out_ovf, n_out_ovf, r_out_eor, n_out_eor;

    sam_pkg::t_data rd0, rd1, rd_sel;
    logic           wr0_en, wr1_en, rd0_en, rd1_en;
    sam_pkg::t_idx  wr0_addr, wr1_addr, rd0_addr, rd1_addr;
    sam_pkg::t_data wr_data;

    sam_pkg::t_cnt  cnt_sel, p_inc, q_inc, a_inc, b_inc;
    logic           full0, full1, swap, sort_wr;
    logic           a_av, b_av, take0, last_res, out_free;
    sam_pkg::t_idx  sort_wr_addr, sort_rd_addr;

    assign cnt_sel = r_sel ? r_cnt1 : r_cnt0;
    assign p_inc   = r_p + ONE_C;
    assign q_inc   = r_q + ONE_C;
    assign a_inc   = r_a + ONE_C;
    assign b_inc   = r_b + ONE_C;
    assign full0   = (r_cnt0 >= DEPTH_C);
    assign full1   = (r_cnt1 >= DEPTH_C);

    assign rd_sel  = r_sel ? rd1 : rd0;
    assign swap    = (r_cur > rd_sel);

    // sort side of the store ports
    assign sort_wr      = (i_cmd.cmp && swap) || i_cmd.wr_p;
    assign sort_wr_addr = i_cmd.wr_p ? r_p[sam_pkg::IDX_W-1:0] : r_q[sam_pkg::IDX_W-1:0];
    assign sort_rd_addr = i_cmd.rd_p   ? r_p[sam_pkg::IDX_W-1:0]
                        : i_cmd.ld_cur ? r_q[sam_pkg::IDX_W-1:0]
                        :                q_inc[sam_pkg::IDX_W-1:0];

    logic sort_rd;
    assign sort_rd = i_cmd.rd_p || i_cmd.ld_cur || (i_cmd.cmp && !o_sts.q_last);

    assign wr_data  = i_cmd.load ? i_value : r_cur;
    assign wr0_en   = (i_cmd.load && !i_list_id && !full0) || (sort_wr && !r_sel);
    assign wr1_en   = (i_cmd.load &&  i_list_id && !full1) || (sort_wr &&  r_sel);
    assign wr0_addr = i_cmd.load ? r_cnt0[sam_pkg::IDX_W-1:0] : sort_wr_addr;
    assign wr1_addr = i_cmd.load ? r_cnt1[sam_pkg::IDX_W-1:0] : sort_wr_addr;

    assign rd0_en   = i_cmd.rd_heads || (sort_rd && !r_sel);
    assign rd1_en   = i_cmd.rd_heads || (sort_rd &&  r_sel);
    assign rd0_addr = i_cmd.rd_heads ? r_a[sam_pkg::IDX_W-1:0] : sort_rd_addr;
    assign rd1_addr = i_cmd.rd_heads ? r_b[sam_pkg::IDX_W-1:0] : sort_rd_addr;

    sam_ram u_ram0 (
        .i_clk     (i_clk),
        .i_wr_en   (wr0_en),
        .i_wr_addr (wr0_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd0_en),
        .i_rd_addr (rd0_addr),
        .o_rd_data (rd0)
    );

    sam_ram u_ram1 (
        .i_clk     (i_clk),
        .i_wr_en   (wr1_en),
        .i_wr_addr (wr1_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd1_en),
        .i_rd_addr (rd1_addr),
        .o_rd_data (rd1)
    );

    // merge: second list wins ties
    assign a_av     = (r_a < r_cnt0);
    assign b_av     = (r_b < r_cnt1);
    assign take0    = a_av && (!b_av || (rd0 < rd1));
    assign last_res = ((a_inc == r_cnt0) && (r_b == r_cnt1)) ||
                      ((r_a == r_cnt0) && (b_inc == r_cnt1));
    assign out_free = !r_out_vld || !i_stall;

    always_comb begin
        n_cnt0    = r_cnt0;
        n_cnt1    = r_cnt1;
        n_drop    = r_drop;
        n_p       = r_p;
        n_q       = r_q;
        n_a       = r_a;
        n_b       = r_b;
        n_sel     = r_sel;
        n_cur     = r_cur;
        n_out_vld = r_out_vld && i_stall;
        n_out_val = r_out_val;
        n_out_src = r_out_src;
        n_out_ovf = r_out_ovf;
        n_out_eor = r_out_eor;

        if (i_cmd.load) begin
            if (!i_list_id) begin
                if (full0) n_drop = 1'b1;
                else       n_cnt0 = r_cnt0 + ONE_C;
            end else begin
                if (full1) n_drop = 1'b1;
                else       n_cnt1 = r_cnt1 + ONE_C;
            end
        end
        if (i_cmd.sort_init) begin
            n_sel = 1'b0;
            n_p   = '0;
            n_a   = '0;
            n_b   = '0;
        end
        if (i_cmd.next_list) begin
            n_sel = 1'b1;
            n_p   = '0;
        end
        if (i_cmd.rd_p) begin
            n_q = p_inc;
        end
        if (i_cmd.ld_cur) begin
            n_cur = rd_sel;
        end
        if (i_cmd.cmp) begin
            n_q = q_inc;
            if (swap) n_cur = rd_sel;
        end
        if (i_cmd.wr_p) begin
            n_p = p_inc;
        end
        if (i_cmd.emit) begin
            n_out_vld = 1'b1;
            n_out_val = take0 ? rd0 : rd1;
            n_out_src = !take0;
            n_out_ovf = r_drop;
            n_out_eor = last_res;
            if (take0) n_a = a_inc;
            else       n_b = b_inc;
            if (last_res) begin
                n_cnt0 = '0;
                n_cnt1 = '0;
                n_drop = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt0    <= '0;
            r_cnt1    <= '0;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cnt0    <= n_cnt0;
            r_cnt1    <= n_cnt1;
            r_drop    <= n_drop;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_q       <= n_q;
        r_a       <= n_a;
        r_b       <= n_b;
        r_sel     <= n_sel;
        r_cur     <= n_cur;
        r_out_val <= n_out_val;
        r_out_src <= n_out_src;
        r_out_ovf <= n_out_ovf;
        r_out_eor <= n_out_eor;
    end

    assign o_sts.sel       = r_sel;
    assign o_sts.p_done    = (p_inc >= cnt_sel);
    assign o_sts.q_last    = (q_inc >= cnt_sel);
    assign o_sts.out_free  = out_free;
    assign o_sts.emit_last = last_res;

    assign o_valid      = r_out_vld;
    assign o_value_res  = r_out_val;
    assign o_from_list  = r_out_src;
    assign o_overflow   = r_out_ovf;
    assign o_end_of_run = r_out_eor;

endmodule

`default_nettype wire

// ===== rtl/sam_ctrl.sv =====
// Controller: one-hot state machine sequencing load, exchange sort of both
// lists and the two-way merge. Depends on sam_pkg.
`default_nettype none

module sam_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  wire                i_last,
    output logic               o_stall,
    input  wire sam_pkg::t_sts i_sts,
    output sam_pkg::t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_LOAD   = 7'b0000001,
        S_P_RD   = 7'b0000010,
        S_P_WAIT = 7'b0000100,
        S_Q_CMP  = 7'b0001000,
        S_P_WR   = 7'b0010000,
        S_M_RD   = 7'b0100000,
        S_M_SEL  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_LOAD: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        o_cmd.sort_init = 1'b1;
                        n_state         = S_P_RD;
                    end
                end
            end
            S_P_RD: begin
                if (i_sts.p_done) begin
                    if (!i_sts.sel) begin
                        o_cmd.next_list = 1'b1;
                    end else begin
                        n_state = S_M_RD;
                    end
                end else begin
                    o_cmd.rd_p = 1'b1;
                    n_state    = S_P_WAIT;
                end
            end
            S_P_WAIT: begin
                o_cmd.ld_cur = 1'b1;
                n_state      = S_Q_CMP;
            end
            S_Q_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.q_last) n_state = S_P_WR;
            end
            S_P_WR: begin
                o_cmd.wr_p = 1'b1;
                n_state    = S_P_RD;
            end
            S_M_RD: begin
                o_cmd.rd_heads = 1'b1;
                n_state        = S_M_SEL;
            end
            S_M_SEL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.emit_last ? S_LOAD : S_M_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sort_and_merge_two_lists.sv =====
// Load: one transaction per cycle; the transaction marked last starts the sort and merge.
// Sort: each pass reads entry p, latches it, compares and swaps every later entry q, then
// writes p back; one compare per cycle via that list's single read port; list 0 then list 1.
// Merge: per result a head read, then a select into the output register; the select waits
// while the output register is held by i_stall. Reset (synchronous, active low) clears
// counts, overflow flag, FSM and output valid; list stores are not cleared.
`default_nettype none

module sort_and_merge_two_lists (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input channel
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_list_id,
    input  wire sam_pkg::t_data i_value,
    input  wire                 i_last,
    // result channel
    output logic                o_valid,
    input  wire                 i_stall,
    output sam_pkg::t_data      o_value_res,
    output logic                o_from_list,
    output logic                o_overflow,
    output logic                o_end_of_run
);

    // command/status pair between the sequencer and the datapath
    sam_pkg::t_cmd cmd;
    sam_pkg::t_sts sts;

    // Sequencer: accepts transactions only in its load state. While sorting,
    // each pass p keeps a running minimum in a register and exchanges it with
    // smaller entries q, so one read and one write per cycle suffice.
    sam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: stores, counters, merge heads and the output register. The
    // output register lets the final result wait while the next run loads.
    sam_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_list_id    (i_list_id),
        .i_value      (i_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_value_res  (o_value_res),
        .o_from_list  (o_from_list),
        .o_overflow   (o_overflow),
        .o_end_of_run (o_end_of_run)
    );

    // a last transaction always starts the sort, so loading stops next cycle
    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last |=> o_stall)
        else $error("load not stopped after last transaction");

    // a result still pending during load can only be the final one of a run
    a_pending_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_stall |-> o_end_of_run)
        else $error("non-final result pending while loading");

    // new results only come out of the merge phase
    a_result_from_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result produced outside merge");

endmodule

`default_nettype wire

// ===== tb/sv/tb_sort_and_merge_two_lists.sv =====
// Self-checking bench for sort_and_merge_two_lists: directed, overflow and random load runs,
// scoreboard against an in-bench merge predictor. Depends on sam_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_sort_and_merge_two_lists;

    localparam int DRAIN_LIMIT = 50000;  // cycles allowed for all queued results to come out
    localparam int TAIL_CYCLES = 400;    // more than one full sort of both lists
    localparam int LIMIT_NS    = 4000000;

    // one merged value as the block should emit it
    typedef struct {
        sam_pkg::t_data value;
        logic           from_list;
        logic           overflow;
        logic           end_of_run;
    } t_merged;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    logic           i_list_id;
    sam_pkg::t_data i_value;
    logic           i_last;
    logic           o_valid;
    logic           i_stall = 1'b0;
    sam_pkg::t_data o_value_res;
    logic           o_from_list;
    logic           o_overflow;
    logic           o_end_of_run;

    // predictor state: both lists kept sorted as they load, plus the sticky drop flag
    sam_pkg::t_data first_sorted[$];
    sam_pkg::t_data second_sorted[$];
    logic           drop_seen;
    t_merged        merged_q[$];

    int mismatch_cnt   = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    sort_and_merge_two_lists u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_list_id    (i_list_id),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value_res  (o_value_res),
        .o_from_list  (o_from_list),
        .o_overflow   (o_overflow),
        .o_end_of_run (o_end_of_run)
    );

    always #4 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // receiver back-pressure, re-rolled every cycle at the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // index where v goes so that lst stays ascending; equal values keep load order
    function automatic int insert_pos(sam_pkg::t_data lst[$], sam_pkg::t_data v);
        int pos;
        pos = 0;
        while (pos < lst.size() && lst[pos] <= v) pos++;
        return pos;
    endfunction

    // Store or drop one accepted transaction; on last, queue the whole merged run.
    task automatic predict_load(input logic id, input sam_pkg::t_data v, input logic last);
        int      ia;
        int      ib;
        int      total;
        logic    take_first;
        t_merged res;
        if (id == 1'b0) begin
            if (first_sorted.size() < sam_pkg::LIST_DEPTH) begin
                first_sorted.insert(insert_pos(first_sorted, v), v);
            end else begin
                drop_seen = 1'b1;
            end
        end else begin
            if (second_sorted.size() < sam_pkg::LIST_DEPTH) begin
                second_sorted.insert(insert_pos(second_sorted, v), v);
            end else begin
                drop_seen = 1'b1;
            end
        end
        if (!last) return;

        ia = 0;
        ib = 0;
        total = first_sorted.size() + second_sorted.size();
        while (ia + ib < total) begin
            // strict less-than: on a tie the second list goes first
            take_first = (ib >= second_sorted.size()) ||
                         (ia < first_sorted.size() && first_sorted[ia] < second_sorted[ib]);
            res.overflow   = drop_seen;
            res.end_of_run = (ia + ib + 1 == total);
            if (take_first) begin
                res.value     = first_sorted[ia];
                res.from_list = 1'b0;
                ia++;
            end else begin
                res.value     = second_sorted[ib];
                res.from_list = 1'b1;
                ib++;
            end
            merged_q.push_back(res);
        end
        first_sorted.delete();
        second_sorted.delete();
        drop_seen = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_merged want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (merged_q.size() == 0) begin
                $error("unexpected result: value_res %0d from_list %0b", o_value_res,
                       o_from_list);
                mismatch_cnt++;
            end else begin
                want = merged_q.pop_front();
                if (o_value_res !== want.value) begin
                    $error("value_res: expected %0d, got %0d", want.value, o_value_res);
                    mismatch_cnt++;
                end
                if (o_from_list !== want.from_list) begin
                    $error("from_list: expected %0b, got %0b", want.from_list, o_from_list);
                    mismatch_cnt++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, o_overflow);
                    mismatch_cnt++;
                end
                if (o_end_of_run !== want.end_of_run) begin
                    $error("end_of_run: expected %0b, got %0b", want.end_of_run, o_end_of_run);
                    mismatch_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // One input transaction. Valid stays high from here until the next call or a
    // drain lowers it; the payload only changes after acceptance.
    task automatic push_item(input logic id, input sam_pkg::t_data v, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_list_id <= id;
        i_value   <= v;
        i_last    <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_load(id, v, last);
        items_sent++;
    endtask

    // Drop valid and hold off until every queued result has come out.
    task automatic wait_drained();
        int guard;
        @(negedge i_clk);
        i_valid <= 1'b0;
        guard = 0;
        while (merged_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (merged_q.size() != 0) begin
            $error("%0d expected results never arrived", merged_q.size());
            mismatch_cnt++;
            merged_q.delete();
        end
    endtask

    // Mix of full-range values, a narrow band (lots of ties) and the extremes.
    function automatic sam_pkg::t_data pick_value();
        case ($urandom_range(3))
            0: return sam_pkg::t_data'($urandom_range(6)) - sam_pkg::t_data'(3);
            1: begin
                case ($urandom_range(3))
                    0: return sam_pkg::t_data'(32'h7FFF_FFFF);
                    1: return sam_pkg::t_data'(32'h8000_0000);
                    2: return sam_pkg::t_data'(0);
                    default: return sam_pkg::t_data'(-1);
                endcase
            end
            default: return sam_pkg::t_data'($urandom);
        endcase
    endfunction

    // Mostly short lists; now and then a full one.
    function automatic int pick_len();
        if ($urandom_range(9) == 0) return sam_pkg::LIST_DEPTH;
        return $urandom_range(5);
    endfunction

    // n0 items to list 0 and n1 to list 1 interleaved at random; final one is last.
    task automatic send_run(input int n0, input int n1);
        int   left0;
        int   left1;
        logic id;
        left0 = n0;
        left1 = n1;
        while (left0 + left1 > 0) begin
            if (left0 == 0) id = 1'b1;
            else if (left1 == 0) id = 1'b0;
            else id = 1'($urandom_range(1));
            if (id) left1--;
            else left0--;
            push_item(id, pick_value(), (left0 + left1) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Single-entry runs, value extremes, cross-list ties, descending input.
    task automatic test_directed();
        // only the second list, max value
        push_item(1'b1, sam_pkg::t_data'(32'h7FFF_FFFF), 1'b1);
        // only the first list, min value
        push_item(1'b0, sam_pkg::t_data'(32'h8000_0000), 1'b1);
        // the same extremes in both lists, plus one differing pair: on each tie the second list wins
        push_item(1'b0, sam_pkg::t_data'(0), 1'b0);
        push_item(1'b1, sam_pkg::t_data'(-1), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(-1), 1'b0);
        push_item(1'b1, sam_pkg::t_data'(0), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(32'h7FFF_FFFF), 1'b0);
        push_item(1'b1, sam_pkg::t_data'(32'h8000_0000), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(32'h8000_0000), 1'b0);
        push_item(1'b1, sam_pkg::t_data'(32'h7FFF_FFFF), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(32'h5555_5555), 1'b0);
        push_item(1'b1, sam_pkg::t_data'(32'hAAAA_AAAA), 1'b1);
        // repeated value inside one list and across
        push_item(1'b0, sam_pkg::t_data'(7), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(7), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(7), 1'b0);
        push_item(1'b1, sam_pkg::t_data'(7), 1'b1);
        // reverse order into the first list, second list left empty
        push_item(1'b0, sam_pkg::t_data'(3), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(2), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(1), 1'b0);
        push_item(1'b0, sam_pkg::t_data'(0), 1'b1);
    endtask

    // Capacity: overfill one list, drop the last transaction itself, fill both.
    task automatic test_overflow();
        send_run(sam_pkg::LIST_DEPTH + 2, 1);
        send_run(0, sam_pkg::LIST_DEPTH + 1);
        send_run(sam_pkg::LIST_DEPTH, sam_pkg::LIST_DEPTH);
    endtask

    task automatic test_random_runs(input int item_goal);
        int start_cnt;
        int n0;
        int n1;
        start_cnt = items_sent;
        while (items_sent - start_cnt < item_goal) begin
            n0 = pick_len();
            n1 = pick_len();
            if (n0 + n1 == 0) n1 = 1;
            send_run(n0, n1);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_list_id = 1'b0;
        i_value   = '0;
        i_last    = 1'b0;
        drop_seen = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // slow sender, busy receiver
        set_idling(24, 55);
        test_directed();
        test_overflow();
        // sender holds off until the block has emptied
        wait_drained();

        // slower sender, less back-pressure from the receiver
        set_idling(55, 24);
        test_random_runs(8);

        // back to back on both sides
        set_idling(0, 0);
        test_random_runs(8);

        wait_drained();
        // anything that shows up now is unexpected and gets flagged by the checker
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
